[rtl/obulf_pkg.sv]
`default_nettype none

package obulf_pkg;

    // Field widths
    localparam int LEN_W       = 28;
    localparam int BYTE_W      = 8;
    localparam int TYPE_W      = 4;
    localparam int GROUP_W     = 7;

    // Size field limit, in LEB128 bytes
    localparam int MAX_SIZE_BYTES = 4;
    localparam int LEB_GROUPS     = (LEN_W + GROUP_W - 1) / GROUP_W;

    // One job carries at most header, extension and the size bytes
    localparam int JOB_BYTES   = 2 + LEB_GROUPS;
    localparam int JOB_CNT_W   = $clog2(JOB_BYTES + 1);
    localparam int JOB_IDX_W   = $clog2(JOB_BYTES);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Byte constants
    localparam logic [BYTE_W-1:0] MORE_FLAG = 8'h80;

    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [JOB_CNT_W-1:0]             count;
        logic                             last;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

[rtl/obulf_queue.sv]
`default_nettype none

module obulf_queue
    import obulf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output qstat_t    stat
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head_job   = mem[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

[rtl/obulf_front.sv]
`default_nettype none

module obulf_front
    import obulf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [TYPE_W-1:0] hdr_type,
    input  wire logic [BYTE_W-1:0] extension,
    input  wire logic [LEN_W-1:0]  payload_length,
    input  wire logic [BYTE_W-1:0] payload_byte,
    input  wire qstat_t            qstat,
    output logic                   push,
    output job_t                   push_job
);

    logic                 frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]     remaining_reg, remaining_next;
    logic                 accept;
    logic                 has_ext;
    logic [JOB_CNT_W-1:0] lsize;
    logic                 reject;
    logic [LEN_W-1:0]     rem_dec;
    logic [LEB_GROUPS-1:0][BYTE_W-1:0] leb;
    logic [LEB_GROUPS-1:0][GROUP_W-1:0] grp;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign has_ext  = (extension != '0);
    assign rem_dec  = remaining_reg - 1'b1;

    // Split the length into seven-bit groups and size the LEB128 field
    always_comb
    begin
        grp   = '0;
        lsize = JOB_CNT_W'(1);
        for (int i = 0; i < LEB_GROUPS; i++)
        begin
            for (int b = 0; b < GROUP_W; b++)
            begin
                if (i * GROUP_W + b < LEN_W)
                begin
                    grp[i][b] = payload_length[i * GROUP_W + b];
                end
            end
        end
        for (int i = 1; i < LEB_GROUPS; i++)
        begin
            if (payload_length >> (i * GROUP_W) != '0)
            begin
                lsize = JOB_CNT_W'(i + 1);
            end
        end
        for (int i = 0; i < LEB_GROUPS; i++)
        begin
            leb[i] = {(JOB_CNT_W'(i + 1) < lsize), grp[i]};
        end
    end

    assign reject = (int'(lsize) > MAX_SIZE_BYTES);

    // Build the job and update the frame state
    always_comb
    begin
        push            = 1'b0;
        push_job        = '0;
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        if (kind == KIND_START)
        begin
            push_job.bytes[0] = {1'b0, hdr_type, has_ext, 1'b1, 1'b0};
            if (has_ext)
            begin
                push_job.bytes[1] = extension;
            end
            for (int i = 0; i < LEB_GROUPS; i++)
            begin
                if (JOB_CNT_W'(i) < lsize)
                begin
                    push_job.bytes[JOB_IDX_W'(i + 1) + JOB_IDX_W'(has_ext)] = leb[i];
                end
            end
            push_job.count = JOB_CNT_W'(1) + JOB_CNT_W'(has_ext) + lsize;
            push_job.last  = (payload_length == '0);
            if (accept)
            begin
                push            = !reject;
                frame_open_next = !reject && (payload_length != '0);
                remaining_next  = reject ? '0 : payload_length;
            end
        end
        else
        begin
            push_job.bytes[0] = payload_byte;
            push_job.count    = JOB_CNT_W'(1);
            push_job.last     = (rem_dec == '0);
            if (accept && frame_open_reg)
            begin
                push            = 1'b1;
                remaining_next  = rem_dec;
                frame_open_next = (rem_dec != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
        end
    end

    // Open frame exactly while payload bytes are still owed
    a_open_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg == (remaining_reg != '0))
        else $error("frame state and remaining count disagree");

    // Never push into a full queue
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push while queue full");

    // A payload job holds exactly one byte
    a_payload_single: assert property (@(posedge clk) disable iff (!rst_n)
        (push && kind == KIND_PAYLOAD) |-> (push_job.count == JOB_CNT_W'(1)))
        else $error("payload job with wrong byte count");

endmodule

`default_nettype wire

[rtl/obulf_back.sv]
`default_nettype none

module obulf_back
    import obulf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire job_t              head_job,
    input  wire qstat_t            qstat,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last
);

    logic [JOB_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 last_reg, last_next;
    logic                 load;
    logic                 final_byte;

    assign load       = !out_valid_reg || out_ready;
    assign final_byte = (JOB_CNT_W'(idx_reg) == head_job.count - 1'b1);

    // Walk the head job one byte per transaction, pop it after its final byte
    always_comb
    begin
        pop            = 1'b0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                out_byte_next = head_job.bytes[idx_reg];
                last_next     = final_byte && head_job.last;
                if (final_byte)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload in the output register
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // Pop only from a non-empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // A part-sent job stays at the head of the queue
    a_idx_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> !qstat.empty)
        else $error("byte index set with no job queued");

    // Index stays inside the head job
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (JOB_CNT_W'(idx_reg) < head_job.count))
        else $error("byte index beyond job length");

endmodule

`default_nettype wire

[rtl/obu_header_leb128_framer_unit.sv]
`default_nettype none

// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+----------------------------------------------
// input   | in        | in_valid / in_ready | kind, hdr_type, extension, payload_length,
//         |           |                     | payload_byte
// output  | out       | out_valid/out_ready | out_byte, last
//
// Payload is taken every cycle the queue has room; its byte is queued, then registered.
// A start transaction yields 2 to 6 bytes (header, optional extension, 1 to 4 size bytes),
// sent one per cycle by the back end unless out_ready stalls; the output register paces it.
// Input stalls only when the four-entry job queue is full; output stalls back up into it.
// Reset clears the frame state, queue pointers and output valid; no clearing pass is needed.

module obu_header_leb128_framer_unit
    import obulf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [TYPE_W-1:0] hdr_type,
    input  wire logic [BYTE_W-1:0] extension,
    input  wire logic [LEN_W-1:0]  payload_length,
    input  wire logic [BYTE_W-1:0] payload_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last
);

    qstat_t qstat;
    job_t   push_job;
    job_t   head_job;
    logic   push;
    logic   pop;

    // Classify transactions and build jobs
    obulf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .hdr_type       (hdr_type),
        .extension      (extension),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .qstat          (qstat),
        .push           (push),
        .push_job       (push_job)
    );

    // Decouple front and back
    obulf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (qstat)
    );

    // Serialise jobs into output bytes
    obulf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import obulf_pkg::*;

    // One input transaction, every field as driven on the ports
    typedef struct packed {
        logic              kind;
        logic [TYPE_W-1:0] typ;
        logic [BYTE_W-1:0] ext;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] pb;
    } txn_t;

    // One framed output byte
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              l;
    } obu_byte_t;

    // Directed stimulus row; eb/el hold typed-in bytes when typed is set
    typedef struct {
        txn_t                   t;
        bit                     typed;
        int                     n;
        logic [0:5][BYTE_W-1:0] eb;
        logic [0:5]             el;
    } row_t;

    localparam logic [LEN_W-1:0] LEN_ALL = {LEN_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_START;
    logic [TYPE_W-1:0] hdr_type = '0;
    logic [BYTE_W-1:0] extension = '0;
    logic [LEN_W-1:0]  payload_length = '0;
    logic [BYTE_W-1:0] payload_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    // Predictor state
    bit                frame_live = 1'b0;
    logic [LEN_W-1:0]  bytes_left = '0;

    obu_byte_t         obu_bytes_due[$];
    int                err_cnt = 0;
    bit                quiet = 1'b0;
    row_t              dir_tab[$];

    obu_header_leb128_framer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .hdr_type       (hdr_type),
        .extension      (extension),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last           (out_last)
    );

    always #4 clk = ~clk;

    function automatic int idle_pct();
        return quiet ? 0 : 20;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // Work out the framed bytes for one transaction and advance the frame state
    function automatic int frame_predict(input txn_t t, output obu_byte_t [0:5] res);
        logic [LEN_W-1:0]  v;
        logic [BYTE_W-1:0] b;
        int                nsz;
        int                n;
        n = 0;
        res = '0;
        if (t.kind == KIND_START) begin
            nsz = 1;
            v = t.len;
            while ((v >> GROUP_W) != 0) begin
                v = v >> GROUP_W;
                nsz++;
            end
            frame_live = 1'b0;
            bytes_left = '0;
            if (nsz > MAX_SIZE_BYTES)
                return 0;
            res[n] = '{{1'b0, t.typ, (t.ext != 0), 1'b1, 1'b0}, 1'b0};
            n++;
            if (t.ext != 0) begin
                res[n] = '{t.ext, 1'b0};
                n++;
            end
            v = t.len;
            for (int i = 0; i < nsz; i++) begin
                b = {1'b0, v[GROUP_W-1:0]};
                v = v >> GROUP_W;
                if (v != 0)
                    b = b | MORE_FLAG;
                res[n] = '{b, (t.len == 0 && i == nsz - 1)};
                n++;
            end
            if (t.len != 0) begin
                frame_live = 1'b1;
                bytes_left = t.len;
            end
            return n;
        end
        // Drop payload outside a frame
        if (!frame_live)
            return 0;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0)
            frame_live = 1'b0;
        res[0] = '{t.pb, (bytes_left == 0)};
        return 1;
    endfunction

    // Present one transaction, hold it until accepted, then queue its bytes
    task automatic apply_txn(input txn_t t, input bit typed, input int tn,
                             input obu_byte_t [0:5] tres, output int n);
        obu_byte_t [0:5] res;
        int              k;
        k = 0;
        while ($urandom_range(99) < idle_pct() && k < 12)
            k++;
        if (k > 0) begin
            in_valid <= 1'b0;
            repeat (k) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= t.kind;
        hdr_type       <= t.typ;
        extension      <= t.ext;
        payload_length <= t.len;
        payload_byte   <= t.pb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = frame_predict(t, res);
        if (typed) begin
            n = tn;
            res = tres;
        end
        for (int i = 0; i < n; i++)
            obu_bytes_due.push_back(res[i]);
    endtask

    function automatic row_t mk_row(input logic kd, input logic [TYPE_W-1:0] typ,
                                    input logic [BYTE_W-1:0] ext,
                                    input logic [LEN_W-1:0] len,
                                    input logic [BYTE_W-1:0] pb, input bit typed,
                                    input int n, input logic [0:5][BYTE_W-1:0] eb,
                                    input logic [0:5] el);
        row_t r;
        r.t     = '{kd, typ, ext, len, pb};
        r.typed = typed;
        r.n     = n;
        r.eb    = eb;
        r.el    = el;
        return r;
    endfunction

    function automatic txn_t rand_start(input logic [LEN_W-1:0] len);
        txn_t t;
        t.kind = KIND_START;
        t.typ  = TYPE_W'($urandom);
        t.ext  = ($urandom_range(99) < 30) ? '0 : BYTE_W'($urandom);
        t.len  = len;
        t.pb   = BYTE_W'($urandom);
        return t;
    endfunction

    function automatic txn_t rand_payload();
        txn_t t;
        t.kind = KIND_PAYLOAD;
        t.typ  = TYPE_W'($urandom);
        t.ext  = BYTE_W'($urandom);
        t.len  = LEN_W'($urandom);
        t.pb   = BYTE_W'($urandom);
        return t;
    endfunction

    // Randomly back-pressure the output
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct());

    // Check each output transaction against the oldest expected byte
    always @(posedge clk)
    begin : mon_b
        obu_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            if (obu_bytes_due.size() == 0) begin
                report_mismatch("unexpected byte", out_byte, 0);
            end
            else begin
                want = obu_bytes_due.pop_front();
                if (out_byte !== want.b)
                    report_mismatch("out_byte", out_byte, want.b);
                if (out_last !== want.l)
                    report_mismatch("last", out_last, want.l);
            end
        end
    end

    // Stimulus
    initial
    begin : stim_b
        obu_byte_t [0:5]  tres;
        txn_t             t;
        logic [LEN_W-1:0] len;
        int               n;
        int               sent;
        int               npl;
        int               roll;

        // Payload outside a frame, zero length, extremes, size-byte boundaries,
        // start during a frame and unused fields
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'hAA, 1, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h0, 8'h00, '0, 8'h00, 1, 2,
                                 {8'h02, 8'h00, 32'h0}, 6'b010000));
        dir_tab.push_back(mk_row(KIND_START, 4'hF, 8'hFF, LEN_ALL, 8'hFF, 1, 6,
                                 {8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F}, 6'b000000));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h1, 8'h00, 28'd1, 8'h00, 1, 2,
                                 {8'h0A, 8'h01, 32'h0}, 6'b000000));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'hFF, 1, 1,
                                 {8'hFF, 40'h0}, 6'b100000));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'h55, 1, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h3, 8'h01, 28'd127, 8'h00, 1, 3,
                                 {8'h1E, 8'h01, 8'h7F, 24'h0}, 6'b000000));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'hF, 8'hFF, LEN_ALL, 8'h12, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h2, 8'h00, 28'd128, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h4, 8'h00, 28'd16383, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h5, 8'h00, 28'd16384, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h6, 8'hA5, 28'd2097151, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h7, 8'h00, 28'd2097152, 8'h00, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h8, 8'h80, 28'd2, 8'hFF, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'h3C, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'hC3, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'h99, 0, 0, '0, '0));
        dir_tab.push_back(mk_row(KIND_START, 4'h9, 8'h7F, '0, 8'h00, 1, 3,
                                 {8'h4E, 8'h7F, 8'h00, 24'h0}, 6'b001000));
        dir_tab.push_back(mk_row(KIND_PAYLOAD, 4'h0, 8'h00, '0, 8'h01, 0, 0, '0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_tab[r]) begin
            for (int i = 0; i < 6; i++)
                tres[i] = '{dir_tab[r].eb[i], dir_tab[r].el[i]};
            apply_txn(dir_tab[r].t, dir_tab[r].typed, dir_tab[r].n, tres, n);
        end

        // Random part: mostly whole frames, some abandoned, plus noise
        sent = 0;
        while (sent < 250) begin
            quiet = (sent >= 100 && sent < 160);
            roll = $urandom_range(99);
            if (roll < 80) begin
                roll = $urandom_range(99);
                if (roll < 10)
                    len = '0;
                else if (roll < 85)
                    len = LEN_W'($urandom_range(1, 12));
                else if (roll < 95)
                    len = LEN_W'($urandom_range(13, 40));
                else
                    len = LEN_W'($urandom) | LEN_W'(1 << $urandom_range(13, 27));
                npl = (len > 40) ? $urandom_range(0, 5) : int'(len);
                if (len != 0 && len <= 40 && $urandom_range(99) < 10)
                    npl = $urandom_range(0, int'(len) - 1);
                apply_txn(rand_start(len), 0, 0, '0, n);
                sent++;
                for (int i = 0; i < npl; i++) begin
                    apply_txn(rand_payload(), 0, 0, '0, n);
                    sent++;
                end
                if ($urandom_range(99) < 10)
                    apply_txn(rand_payload(), 0, 0, '0, n);
            end
            else begin
                if ($urandom_range(1) == 1)
                    t = rand_payload();
                else
                    t = rand_start(LEN_W'($urandom >> $urandom_range(4, 31)));
                apply_txn(t, 0, 0, '0, n);
                if (n > 0)
                    sent++;
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain, then allow for late stray bytes
        while (obu_bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard
    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
